// ===== rtl/hkrd_pkg.sv =====
// hkrd_pkg: shared types and constants for the keyboard report diff unit
// no dependencies

package hkrd_pkg;

	localparam int SLOT_MAX   = 6;
	localparam int EVENT_BITS = 2 * SLOT_MAX;
	localparam int EVENT_IDX_W = $clog2(EVENT_BITS);
	localparam int SLOT_IDX_W  = $clog2(SLOT_MAX);

	localparam logic [6:0] MIN_REPORT_BYTES = 7'd8;
	localparam logic [7:0] HIGHEST_NON_KEY  = 8'd3;

	typedef logic [7:0] key_code_t;
	typedef logic [SLOT_MAX-1:0][7:0] key_arr_t;
	typedef logic [EVENT_BITS-1:0] event_mask_t;

	// one classified report: bit 2i is a release of old slot i, bit 2i+1 a press of new slot i
	typedef struct packed {
		key_arr_t    old_keys;
		key_arr_t    new_keys;
		key_code_t   modifier;
		event_mask_t mask;
	} entry_t;

endpackage

// ===== rtl/hkrd_queue.sv =====
// hkrd_queue: small register queue of classified reports between front and back
// depends on hkrd_pkg

module hkrd_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  hkrd_pkg::entry_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output hkrd_pkg::entry_t pop_data
);
	import hkrd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/hkrd_front.sv =====
// hkrd_front: accepts reports, compares them with the stored key codes and
// classifies the press and release events; depends on hkrd_pkg

module hkrd_front #(
	parameter int KEY_SLOTS = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [6:0]        report_length,
	input  hkrd_pkg::key_code_t modifier_bits,
	input  hkrd_pkg::key_arr_t  key_slots,
	output logic              push_valid,
	input  logic              push_ready,
	output hkrd_pkg::entry_t    push_data
);
	import hkrd_pkg::*;

	key_code_t   prev_keys_q [KEY_SLOTS];
	key_arr_t    old_keys;
	key_arr_t    new_keys;
	event_mask_t mask;
	logic        long_enough;
	logic        update;

	for (genvar g = 0; g < SLOT_MAX; g++) begin : g_slot
		if (g < KEY_SLOTS) begin : g_used
			assign old_keys[g] = prev_keys_q[g];
			assign new_keys[g] = key_slots[g];
		end else begin : g_unused
			assign old_keys[g] = '0;
			assign new_keys[g] = '0;
		end
	end

	always_comb begin
		logic old_in_new;
		logic new_in_old;
		mask = '0;
		for (int i = 0; i < SLOT_MAX; i++) begin
			old_in_new = 1'b0;
			new_in_old = 1'b0;
			for (int j = 0; j < SLOT_MAX; j++) begin
				old_in_new = old_in_new | (new_keys[j] == old_keys[i]);
				new_in_old = new_in_old | (old_keys[j] == new_keys[i]);
			end
			mask[2*i]   = (old_keys[i] > HIGHEST_NON_KEY) && !old_in_new;
			mask[2*i+1] = (new_keys[i] > HIGHEST_NON_KEY) && !new_in_old;
		end
	end

	assign long_enough = (report_length >= MIN_REPORT_BYTES);
	assign in_ready    = push_ready;
	assign update      = in_valid && in_ready && long_enough;

	assign push_valid         = in_valid && long_enough && (mask != '0);
	assign push_data.old_keys = old_keys;
	assign push_data.new_keys = new_keys;
	assign push_data.modifier = modifier_bits;
	assign push_data.mask     = mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_keys_q[i] <= '0;
			end
		end else if (update) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_keys_q[i] <= new_keys[i];
			end
		end
	end

endmodule

// ===== rtl/hkrd_back.sv =====
// hkrd_back: walks the event mask of one queued report, one event a cycle
// unless out_ready stalls it, into the output register; depends on hkrd_pkg

module hkrd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  hkrd_pkg::entry_t    pop_data,
	output logic              out_valid,
	input  logic              out_ready,
	output hkrd_pkg::key_code_t event_key,
	output hkrd_pkg::key_code_t event_modifier,
	output logic              is_press,
	output logic              last_event
);
	import hkrd_pkg::*;

	entry_t                 cur_q;
	logic                   busy_q;
	logic                   out_valid_q;
	key_code_t              event_key_q;
	key_code_t              event_modifier_q;
	logic                   is_press_q;
	logic                   last_event_q;

	logic [EVENT_IDX_W-1:0] idx;
	logic [SLOT_IDX_W-1:0]  slot;
	event_mask_t            remaining;
	logic                   emit;
	logic                   load;
	logic                   done;

	// lowest pending event first
	always_comb begin
		idx = '0;
		for (int i = EVENT_BITS - 1; i >= 0; i--) begin
			if (cur_q.mask[i]) begin
				idx = EVENT_IDX_W'(i);
			end
		end
	end

	assign slot      = idx[EVENT_IDX_W-1:1];
	assign remaining = cur_q.mask & ~(event_mask_t'(1) << idx);
	assign done      = (remaining == '0);
	assign emit      = busy_q && (!out_valid_q || out_ready);
	assign load      = pop_valid && (!busy_q || (emit && done));
	assign pop_ready = load;

	assign out_valid      = out_valid_q;
	assign event_key      = event_key_q;
	assign event_modifier = event_modifier_q;
	assign is_press       = is_press_q;
	assign last_event     = last_event_q;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= pop_data;
		end else if (emit) begin
			cur_q.mask <= remaining;
		end
		if (emit) begin
			event_key_q      <= idx[0] ? cur_q.new_keys[slot] : cur_q.old_keys[slot];
			event_modifier_q <= idx[0] ? cur_q.modifier : '0;
			is_press_q       <= idx[0];
			last_event_q     <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && done) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/hid_keyboard_report_diff_unit.sv =====
// hid_keyboard_report_diff_unit: top level of the boot keyboard report diff unit
// depends on hkrd_pkg, hkrd_front, hkrd_queue, hkrd_back

// Takes one boot keyboard report per request and emits one key event per
// cycle unless out_ready stalls it: for each slot in order a release of the
// old code if it has left the report, then a press of the new code if it is
// new, last_event marking the final one. Reports shorter than 8 bytes and
// reports that change nothing give no events. The front compares a report in
// the cycle it is accepted and queues it; it takes a new report every cycle
// while the queue (QUEUE_DEPTH reports) has room. The back drains a report
// event by event, 0 to 2*KEY_SLOTS events, 12 at most, and consecutive
// reports follow each other without a gap.

module hid_keyboard_report_diff_unit #(
	parameter int KEY_SLOTS   = 6,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [6:0] report_length,
	input  logic [7:0] modifier_bits,
	input  logic [7:0] key_slot_0,
	input  logic [7:0] key_slot_1,
	input  logic [7:0] key_slot_2,
	input  logic [7:0] key_slot_3,
	input  logic [7:0] key_slot_4,
	input  logic [7:0] key_slot_5,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] event_key,
	output logic [7:0] event_modifier,
	output logic       is_press,
	output logic       last_event
);
	import hkrd_pkg::*;

	key_arr_t key_slots;
	entry_t   push_data;
	entry_t   pop_data;
	logic     push_valid;
	logic     push_ready;
	logic     pop_valid;
	logic     pop_ready;

	assign key_slots[0] = key_slot_0;
	assign key_slots[1] = key_slot_1;
	assign key_slots[2] = key_slot_2;
	assign key_slots[3] = key_slot_3;
	assign key_slots[4] = key_slot_4;
	assign key_slots[5] = key_slot_5;

	hkrd_front #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.report_length (report_length),
		.modifier_bits (modifier_bits),
		.key_slots     (key_slots),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_data     (push_data)
	);

	hkrd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	hkrd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_data       (pop_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_key      (event_key),
		.event_modifier (event_modifier),
		.is_press       (is_press),
		.last_event     (last_event)
	);

endmodule

// ===== verif/tb_hid_keyboard_report_diff_unit.sv =====
// tb_hid_keyboard_report_diff_unit: self-checking testbench for the keyboard report diff unit
// depends on hkrd_pkg and hid_keyboard_report_diff_unit; predicts key events per accepted report
// directed reports first, then random reports with random gaps and stalls on both sides

`timescale 1ns / 1ps

module tb_hid_keyboard_report_diff_unit;
	import hkrd_pkg::*;

	localparam int SLOTS_USED     = 6;
	localparam int RANDOM_REPORTS = 190;
	localparam int IDLE_LIMIT     = 3000;
	localparam int LONG_HOLD      = 250;

	typedef struct {
		logic [6:0] len;
		logic [7:0] mods;
		key_arr_t   keys;
		int         gap;
		bit         drain;
	} report_t;

	typedef struct {
		key_code_t  key;
		logic [7:0] mods;
		logic       press;
		logic       last;
	} key_change_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [6:0] report_length = '0;
	logic [7:0] modifier_bits = '0;
	logic [7:0] key_slot_0 = '0;
	logic [7:0] key_slot_1 = '0;
	logic [7:0] key_slot_2 = '0;
	logic [7:0] key_slot_3 = '0;
	logic [7:0] key_slot_4 = '0;
	logic [7:0] key_slot_5 = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] event_key;
	logic [7:0] event_modifier;
	logic       is_press;
	logic       last_event;

	report_t     report_backlog[$];
	key_change_t due_events[$];
	key_arr_t    held_keys = '0;
	report_t     cur;
	key_change_t exp_ev;
	int          total_reports = 0;
	int          reports_taken = 0;
	int          events_checked = 0;
	int          fail_count = 0;
	int          idle_left = 0;
	int          hold_left = 0;
	int          idle_cycles = 0;
	bit          long_hold_done = 1'b0;
	bit          wind_down = 1'b0;

	hid_keyboard_report_diff_unit #(
		.KEY_SLOTS(SLOTS_USED)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.report_length (report_length),
		.modifier_bits (modifier_bits),
		.key_slot_0    (key_slot_0),
		.key_slot_1    (key_slot_1),
		.key_slot_2    (key_slot_2),
		.key_slot_3    (key_slot_3),
		.key_slot_4    (key_slot_4),
		.key_slot_5    (key_slot_5),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_key     (event_key),
		.event_modifier(event_modifier),
		.is_press      (is_press),
		.last_event    (last_event)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic bit key_listed(input key_arr_t codes, input key_code_t code);
		for (int i = 0; i < SLOTS_USED; i++) begin
			if (codes[i] == code)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// key events of one report, appended to the due queue
	task automatic diff_report(input logic [6:0] len, input logic [7:0] mods,
			input key_arr_t fresh);
		key_change_t evs[$];
		key_change_t ev;
		if (len < MIN_REPORT_BYTES)
			return;
		for (int i = 0; i < SLOTS_USED; i++) begin
			if (held_keys[i] > HIGHEST_NON_KEY && !key_listed(fresh, held_keys[i])) begin
				ev = '{key: held_keys[i], mods: 8'd0, press: 1'b0, last: 1'b0};
				evs.push_back(ev);
			end
			if (fresh[i] > HIGHEST_NON_KEY && !key_listed(held_keys, fresh[i])) begin
				ev = '{key: fresh[i], mods: mods, press: 1'b1, last: 1'b0};
				evs.push_back(ev);
			end
		end
		if (evs.size() > 0)
			evs[evs.size() - 1].last = 1'b1;
		foreach (evs[i])
			due_events.push_back(evs[i]);
		held_keys = fresh;
	endtask

	task automatic add_report(input logic [6:0] len, input logic [7:0] mods,
			input key_code_t k0, input key_code_t k1, input key_code_t k2,
			input key_code_t k3, input key_code_t k4, input key_code_t k5,
			input int gap, input bit drain);
		report_t r;
		r.len = len;
		r.mods = mods;
		r.keys = {k5, k4, k3, k2, k1, k0};
		r.gap = gap;
		r.drain = drain;
		report_backlog.push_back(r);
	endtask

	function automatic key_code_t pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return 8'd0;
		else if (r < 30)
			return key_code_t'($urandom_range(1, 3));
		else if (r < 85)
			return key_code_t'($urandom_range(4, 11));
		return key_code_t'($urandom_range(0, 255));
	endfunction

	function automatic int pick_gap(input int idx);
		int r;
		if (idx >= 40 && idx < 110)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				diff_report(report_length, modifier_bits, {key_slot_5, key_slot_4,
					key_slot_3, key_slot_2, key_slot_1, key_slot_0});
				reports_taken++;
				idle_left = (report_backlog.size() > 0) ? report_backlog[0].gap : 0;
			end
			if (!in_valid || in_ready) begin
				if (idle_left > 0) begin
					idle_left--;
					in_valid <= 1'b0;
				end else if (report_backlog.size() == 0 ||
						(report_backlog[0].drain && due_events.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					cur = report_backlog.pop_front();
					in_valid <= 1'b1;
					report_length <= cur.len;
					modifier_bits <= cur.mods;
					key_slot_0 <= cur.keys[0];
					key_slot_1 <= cur.keys[1];
					key_slot_2 <= cur.keys[2];
					key_slot_3 <= cur.keys[3];
					key_slot_4 <= cur.keys[4];
					key_slot_5 <= cur.keys[5];
				end
			end
		end
	end

	// monitor and result checking
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_events.size() == 0) begin
					$error("event_key: expected no event, actual %0d", event_key);
					fail_count++;
				end else begin
					exp_ev = due_events.pop_front();
					if (event_key !== exp_ev.key) begin
						$error("event_key: expected %0d, actual %0d", exp_ev.key, event_key);
						fail_count++;
					end
					if (event_modifier !== exp_ev.mods) begin
						$error("event_modifier: expected %0d, actual %0d", exp_ev.mods,
							event_modifier);
						fail_count++;
					end
					if (is_press !== exp_ev.press) begin
						$error("is_press: expected %0d, actual %0d", exp_ev.press, is_press);
						fail_count++;
					end
					if (last_event !== exp_ev.last) begin
						$error("last_event: expected %0d, actual %0d", exp_ev.last,
							last_event);
						fail_count++;
					end
				end
				events_checked++;
			end
			if (!long_hold_done && events_checked >= 60) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (wind_down) begin
				out_ready <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if ((events_checked / 50) % 3 == 0) begin
				out_ready <= 1'b1;
			end else begin
				case ($urandom_range(0, 99)) inside
					[0:19]: begin
						hold_left = $urandom_range(0, 2);
						out_ready <= 1'b0;
					end
					[20:22]: begin
						hold_left = $urandom_range(10, 30);
						out_ready <= 1'b0;
					end
					default: out_ready <= 1'b1;
				endcase
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		key_arr_t last_keys;
		report_t  r;
		int       long_count;

		// directed reports
		add_report(7'd8,   8'h00, 8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   0, 1'b0);
		add_report(7'd8,   8'h11, 8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   0, 1'b0);
		add_report(7'd7,   8'hFF, 8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  1, 1'b0);
		add_report(7'd0,   8'hFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 0, 1'b0);
		add_report(7'd127, 8'hFF, 8'd255, 8'd254, 8'd253, 8'd252, 8'd251, 8'd250, 0, 1'b0);
		add_report(7'd64,  8'h5A, 8'd0,   8'd1,   8'd2,   8'd3,   8'd0,   8'd0,   2, 1'b0);
		add_report(7'd8,   8'hA5, 8'd4,   8'd4,   8'd4,   8'd3,   8'd255, 8'd4,   0, 1'b0);
		add_report(7'd9,   8'h01, 8'd4,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   0, 1'b0);
		add_report(7'd8,   8'h80, 8'd5,   8'd4,   8'd6,   8'd0,   8'd0,   8'd0,   3, 1'b0);
		add_report(7'd8,   8'h00, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   0, 1'b0);
		add_report(7'd6,   8'h3C, 8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   0, 1'b0);
		add_report(7'd65,  8'h0F, 8'h80,  8'h40,  8'h20,  8'h10,  8'h08,  8'h04,  0, 1'b0);
		add_report(7'd8,   8'hF0, 8'h7F,  8'hBF,  8'hDF,  8'hEF,  8'hF7,  8'hFB,  0, 1'b0);
		add_report(7'd127, 8'h02, 8'h7F,  8'hBF,  8'hDF,  8'hEF,  8'hF7,  8'hFB,  0, 1'b1);
		add_report(7'd8,   8'h20, 8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   0, 1'b0);
		add_report(7'd8,   8'h20, 8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   0, 1'b0);
		add_report(7'd8,   8'h44, 8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   0, 1'b0);

		// random reports, mostly well formed, a few short ones in between
		last_keys = '0;
		long_count = 0;
		while (long_count < RANDOM_REPORTS) begin
			r.gap = pick_gap(long_count);
			r.drain = (long_count == 0 || long_count == 150);
			r.mods = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 99) < 15) begin
				r.keys = last_keys;
			end else begin
				for (int i = 0; i < SLOTS_USED; i++)
					r.keys[i] = pick_key();
			end
			case ($urandom_range(0, 99)) inside
				[0:9]: r.len = 7'($urandom_range(0, 7));
				[10:79]: r.len = 7'd8;
				[80:93]: r.len = 7'($urandom_range(9, 64));
				default: r.len = 7'($urandom_range(65, 127));
			endcase
			if (r.len >= MIN_REPORT_BYTES) begin
				long_count++;
				last_keys = r.keys;
			end
			report_backlog.push_back(r);
		end
		total_reports = report_backlog.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (reports_taken < total_reports)
			@(posedge clk);
		wind_down = 1'b1;
		while (due_events.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (fail_count == 0 && due_events.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/hkrd_pkg.sv
rtl/hkrd_queue.sv
rtl/hkrd_front.sv
rtl/hkrd_back.sv
rtl/hid_keyboard_report_diff_unit.sv
verif/tb_hid_keyboard_report_diff_unit.sv
